>>> rtl/cfv_pkg.sv
`timescale 1ns / 1ps

package cfv_pkg;

  // Verdict codes carried in the status field of every result item.
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_START      = 3'd1,
    ST_BAD_COMPLEMENT = 3'd2,
    ST_BAD_LENGTH     = 3'd3,
    ST_BAD_CHECKSUM   = 3'd4
  } status_t;

  // Item kinds on the input channel.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  localparam logic [7:0] START_BYTE_RESET = 8'hFE;
  localparam logic [7:0] MIN_LENGTH       = 8'd8;
  localparam logic [7:0] LENGTH_POS       = 8'd6;
  localparam logic [7:0] COMMAND_POS      = 8'd7;
  localparam logic [7:0] FIRST_COMP_POS   = 8'd3;
  localparam logic [7:0] SECOND_COMP_POS  = 8'd4;
  localparam int unsigned SUM_MODULUS     = 100;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic [7:0] header_first;
    logic [7:0] header_second;
  } result_t;

  // Reduces a value below 3 * SUM_MODULUS + SUM_MODULUS into 0..99 with three
  // parallel compares; the running sum plus one byte never exceeds 354.
  function automatic logic [6:0] mod_hundred(input logic [8:0] v);
    logic [8:0] r;
    begin
      if (v >= 9'(3 * SUM_MODULUS)) begin
        r = v - 9'(3 * SUM_MODULUS);
      end else if (v >= 9'(2 * SUM_MODULUS)) begin
        r = v - 9'(2 * SUM_MODULUS);
      end else if (v >= 9'(SUM_MODULUS)) begin
        r = v - 9'(SUM_MODULUS);
      end else begin
        r = v;
      end
      return r[6:0];
    end
  endfunction

endpackage

>>> rtl/cfv_ifs.sv
`timescale 1ns / 1ps

// Input channel: one received byte or an abort per item.
interface cfv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one verdict per frame.
interface cfv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] command;
  logic [7:0] frame_length;
  logic [7:0] header_first;
  logic [7:0] header_second;

  modport source (output valid, output status, output command, output frame_length,
                  output header_first, output header_second, input ready);
  modport sink   (input valid, input status, input command, input frame_length,
                  input header_first, input header_second, output ready);
endinterface

// Configuration write channel for the start byte register.
interface cfv_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cfv_frame_engine.sv
`timescale 1ns / 1ps

module cfv_frame_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic            kind,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      start_byte,
  output logic            res_valid,
  output cfv_pkg::result_t res
);
  import cfv_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [6:0] sum_r, sum_nxt;
  logic [7:0] hdr0_r, hdr0_nxt;
  logic [7:0] hdr1_r, hdr1_nxt;
  logic [7:0] hdr2_r, hdr2_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       cgood_r, cgood_nxt;

  logic       do_clear;
  logic [7:0] comp_ref;
  logic [7:0] cmd_cur;
  logic       last_byte;

  assign comp_ref  = (pos_r == FIRST_COMP_POS)  ? hdr0_r :
                     (pos_r == SECOND_COMP_POS) ? hdr1_r : hdr2_r;
  // With a length of eight the command byte is also the checksum byte.
  assign cmd_cur   = (pos_r == COMMAND_POS) ? data_byte : cmd_r;
  assign last_byte = ({1'b0, pos_r} + 9'd1) == {1'b0, exp_len_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    exp_len_nxt  = exp_len_r;
    sum_nxt      = sum_r;
    hdr0_nxt     = hdr0_r;
    hdr1_nxt     = hdr1_r;
    hdr2_nxt     = hdr2_r;
    cmd_nxt      = cmd_r;
    cgood_nxt    = cgood_r;
    do_clear     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    if (fire) begin
      if (kind == KIND_ABORT) begin
        do_clear = 1'b1;
      end else if (!in_frame_r) begin
        if (data_byte != start_byte) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_START;
        end else begin
          do_clear = 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 8'd1;
        if (pos_r < FIRST_COMP_POS) begin
          if (pos_r[1:0] == 2'd1) begin
            hdr1_nxt = data_byte;
          end else begin
            hdr2_nxt = data_byte;
          end
        end else if (pos_r < LENGTH_POS) begin
          if (comp_ref != ~data_byte) begin
            cgood_nxt = 1'b0;
          end
        end else if (pos_r == LENGTH_POS) begin
          exp_len_nxt = data_byte;
          if (data_byte < MIN_LENGTH) begin
            res_valid         = 1'b1;
            res.status        = ST_BAD_LENGTH;
            res.frame_length  = data_byte;
            res.header_first  = hdr1_r;
            res.header_second = hdr2_r;
            do_clear          = 1'b1;
          end else begin
            sum_nxt = mod_hundred({1'b0, data_byte});
          end
        end else begin
          cmd_nxt = cmd_cur;
          if (last_byte) begin
            res_valid = 1'b1;
            if (!cgood_r) begin
              res.status = ST_BAD_COMPLEMENT;
            end else if ({1'b0, sum_r} != data_byte) begin
              res.status = ST_BAD_CHECKSUM;
            end else begin
              res.status = ST_OK;
            end
            res.command       = cmd_cur;
            res.frame_length  = exp_len_r;
            res.header_first  = hdr1_r;
            res.header_second = hdr2_r;
            do_clear          = 1'b1;
          end else begin
            sum_nxt = mod_hundred({2'b00, sum_r} + {1'b0, data_byte});
          end
        end
      end

      if (do_clear) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        exp_len_nxt  = '0;
        sum_nxt      = '0;
        hdr0_nxt     = '0;
        hdr1_nxt     = '0;
        hdr2_nxt     = '0;
        cmd_nxt      = '0;
        cgood_nxt    = 1'b1;
        // A matching start byte opens a fresh frame right after the clear.
        if (kind == KIND_DATA && !in_frame_r) begin
          in_frame_nxt = 1'b1;
          hdr0_nxt     = data_byte;
          pos_nxt      = 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      exp_len_r  <= '0;
      sum_r      <= '0;
      hdr0_r     <= '0;
      hdr1_r     <= '0;
      hdr2_r     <= '0;
      cmd_r      <= '0;
      cgood_r    <= 1'b1;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      exp_len_r  <= exp_len_nxt;
      sum_r      <= sum_nxt;
      hdr0_r     <= hdr0_nxt;
      hdr1_r     <= hdr1_nxt;
      hdr2_r     <= hdr2_nxt;
      cmd_r      <= cmd_nxt;
      cgood_r    <= cgood_nxt;
    end
  end

endmodule

>>> rtl/cfv_out_stage.sv
`timescale 1ns / 1ps

module cfv_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cfv_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output cfv_pkg::result_t res_out,
  output logic             free
);
  import cfv_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

>>> rtl/checksum_frame_validator_core.sv
`timescale 1ns / 1ps

// Checksum frame validator. Items on in_ch are received bytes (kind 0) or an
// abort (kind 1) that drops any partial frame without a result. Every frame
// starts with the configured start byte, carries two header bytes, their
// three complements (start byte included), a length byte L, a command byte,
// payload and a checksum byte at position L-1 that must equal the sum modulo
// 100 of the bytes from the length byte up to the byte before the checksum.
// One result item on out_ch reports each frame: ok, bad complement or bad
// checksum at the last byte, bad length as soon as L is below 8, and bad
// start for each stray byte seen between frames. The block takes one item
// per clock cycle; an item passes an input register and then the frame logic
// into the result register, from which out_ch is offered the verdict after
// the frame logic has processed the last byte. Input stalls only while the
// result register holds an item that out_ch does not take. The start byte
// resets to 0xFE; the user must write it through cfg_ch only while the block
// is idle, which the block itself does not enforce.
module checksum_frame_validator_core (
  input  logic      clk,
  input  logic      rst_n,
  cfv_in_if.sink    in_ch,
  cfv_out_if.source out_ch,
  cfv_cfg_if.sink   cfg_ch
);
  import cfv_pkg::*;

  logic [7:0] start_byte_r;

  // Input register.
  logic       p_valid_r, p_valid_nxt;
  logic       p_kind_r;
  logic [7:0] p_byte_r;

  logic       out_free;
  logic       proc_fire;
  logic       in_fire;
  logic       res_valid;
  result_t    res_eng;
  result_t    res_out;

  // The configuration register is always ready to be written.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RESET;
    end else if (cfg_ch.valid) begin
      start_byte_r <= cfg_ch.data;
    end
  end

  // The held item moves on whenever the result register can take a verdict,
  // so a new byte enters in the same cycle the held one is processed.
  assign proc_fire   = p_valid_r && out_free;
  assign in_ch.ready = !p_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_fire) begin
      p_valid_nxt = 1'b1;
    end else if (proc_fire) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_kind_r <= in_ch.kind;
      p_byte_r <= in_ch.data_byte;
    end
  end

  cfv_frame_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (proc_fire),
    .kind       (p_kind_r),
    .data_byte  (p_byte_r),
    .start_byte (start_byte_r),
    .res_valid  (res_valid),
    .res        (res_eng)
  );

  cfv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res_eng),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res_out   (res_out),
    .free      (out_free)
  );

  assign out_ch.status        = res_out.status;
  assign out_ch.command       = res_out.command;
  assign out_ch.frame_length  = res_out.frame_length;
  assign out_ch.header_first  = res_out.header_first;
  assign out_ch.header_second = res_out.header_second;

endmodule
